@@ rtl/fsk_pulse_sync_and_bit_decoder_unit_assert.svh @@
// assertion macros for the fsk pulse sync and bit decoder unit
// used by the top level only, needs clk and rst in scope
`ifndef FSK_PULSE_SYNC_AND_BIT_DECODER_UNIT_ASSERT_SVH
`define FSK_PULSE_SYNC_AND_BIT_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define FPSBD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpsbd check failed");

// next-cycle implication
`define FPSBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpsbd check failed");

`endif

@@ rtl/fpsbd_pkg.sv @@
// shared types and constants of the fsk pulse sync and bit decoder
// no dependencies
package fpsbd_pkg;

  localparam int unsigned SyncCountWidth = 8;
  localparam int unsigned OutTimeWidth   = 8;
  localparam logic [SyncCountWidth-1:0] SyncCountReset = 8'd8;
  localparam logic [SyncCountWidth-1:0] MatchMax       = 8'hFF;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_HUNT_LOW  = 3'd1,
    PH_HUNT_HIGH = 3'd2,
    PH_BIT_WAIT  = 3'd3,
    PH_BIT_TIME  = 3'd4
  } phase_t;

  typedef enum logic {
    EV_SYNC = 1'b0,
    EV_BIT  = 1'b1
  } event_kind_t;

  typedef struct packed {
    logic start_sync;
    logic pin_level;
  } in_item_t;

  typedef struct packed {
    logic                    high_longer;
    logic [OutTimeWidth-1:0] high_time;
    logic [OutTimeWidth-1:0] low_time;
    logic                    bit_value;
    event_kind_t             event_kind;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } dec_out_t;

endpackage

@@ rtl/fsk_pulse_sync_and_bit_decoder_unit.sv @@
// channel   | bus                          | request
// input     | s_tvalid s_tready s_tdata    | one line sample per timer tick
// output    | m_tvalid m_tready m_tdata/user | sync or decoded bit event
// config    | cfg_we cfg_wdata             | sync_count write
// an accepted sample waits in the input register until the output register is free and is then decoded,
// so its event, if any, is registered in the output register and valid on the output from there
// one sample per cycle sustained while the output is not held, set by the single state update per tick
// rst is synchronous; reset state is idle with sync_count 8
// a held output stalls the input register, which still takes one more sample
// top level, depends on fpsbd_pkg, fpsbd_in_stage, fpsbd_decode, fpsbd_out_reg
`include "fsk_pulse_sync_and_bit_decoder_unit_assert.svh"
module fsk_pulse_sync_and_bit_decoder_unit #(
  parameter int unsigned TIME_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // pin_level, start_sync, zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // bit_value, low_time[7:0], high_time[7:0], high_longer, zero fill
  output logic        m_tuser,   // event_kind
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  fpsbd_pkg::in_item_t s_item, item;
  fpsbd_pkg::dec_out_t dec;
  fpsbd_pkg::result_t  res;
  logic stage_valid, out_free, advance;

  assign s_item.pin_level  = s_tdata[0];
  assign s_item.start_sync = s_tdata[1];
  assign advance = stage_valid && out_free;

  fpsbd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_item   (s_item),
    .advance  (advance),
    .valid    (stage_valid),
    .item     (item)
  );

  fpsbd_decode #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dec (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .en        (advance),
    .item      (item),
    .dec       (dec)
  );

  fpsbd_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .dec      (dec),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res      (res)
  );

  assign m_tuser = res.event_kind;
  assign m_tdata = {6'd0, res.high_longer, res.high_time, res.low_time, res.bit_value};

  `FPSBD_ASSERT_NOW(a_stall_cause, !s_tready, stage_valid && m_tvalid && !m_tready)
  `FPSBD_ASSERT_NOW(a_sync_no_bit, m_tvalid && (m_tuser == fpsbd_pkg::EV_SYNC), !m_tdata[0])
  `FPSBD_ASSERT_NOW(a_bit_no_times, m_tvalid && (m_tuser == fpsbd_pkg::EV_BIT),
                    m_tdata[17:1] == 17'd0)
  `FPSBD_ASSERT_NEXT(a_event_follows, advance && dec.valid, m_tvalid)

endmodule

@@ rtl/fpsbd_in_stage.sv @@
// input register of the fsk pulse sync and bit decoder
// depends on fpsbd_pkg
module fpsbd_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  fpsbd_pkg::in_item_t s_item,
  input  logic               advance,
  output logic               valid,
  output fpsbd_pkg::in_item_t item
);

  assign s_tready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= s_item;
    end
  end

endmodule

@@ rtl/fpsbd_decode.sv @@
// pulse timing, preamble match and bit decision state machine
// depends on fpsbd_pkg
module fpsbd_decode #(
  parameter int unsigned TIME_WIDTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic                en,
  input  fpsbd_pkg::in_item_t item,
  output fpsbd_pkg::dec_out_t dec
);

  fpsbd_pkg::phase_t phase, phase_next;
  logic [TIME_WIDTH-1:0] tick_count, tick_count_next;
  logic [7:0] match_count, match_count_next;
  logic [7:0] sync_count;
  logic [TIME_WIDTH-1:0] prev_high_time, prev_high_time_next;
  logic [TIME_WIDTH-1:0] ref_low_time, ref_low_time_next;
  logic [TIME_WIDTH-1:0] ref_high_time, ref_high_time_next;
  logic longer_is_high, longer_is_high_next;
  logic last_level, last_level_next;

  logic [TIME_WIDTH-1:0] t, tol, ref_sel;
  logic [TIME_WIDTH:0] win_lo, win_hi, bit_thr;
  logic is_match, pulse_edge, longer_new;
  logic [7:0] match_upd;

  always_comb begin
    t        = tick_count + TIME_WIDTH'(1);
    tol      = t >> 2;
    win_lo   = {1'b0, t} - {1'b0, tol};
    win_hi   = {1'b0, t} + {1'b0, tol};
    is_match = ({1'b0, prev_high_time} > win_lo) && ({1'b0, prev_high_time} < win_hi);
    match_upd = is_match ? ((match_count == fpsbd_pkg::MatchMax) ? match_count
                                                                 : match_count + 8'd1)
                         : 8'd0;
    longer_new = t > ref_low_time;
    ref_sel  = longer_is_high ? ref_high_time : ref_low_time;
    bit_thr  = {1'b0, ref_sel} + {1'b0, ref_sel >> 2};

    phase_next          = phase;
    match_count_next    = match_count;
    prev_high_time_next = prev_high_time;
    ref_low_time_next   = ref_low_time;
    ref_high_time_next  = ref_high_time;
    longer_is_high_next = longer_is_high;
    last_level_next     = last_level;
    pulse_edge          = 1'b0;
    dec                 = '0;

    case (phase)
      fpsbd_pkg::PH_HUNT_LOW: begin
        if (item.pin_level) begin
          pulse_edge        = 1'b1;
          ref_low_time_next = t;
          last_level_next   = 1'b1;
          phase_next        = fpsbd_pkg::PH_HUNT_HIGH;
        end
      end
      fpsbd_pkg::PH_HUNT_HIGH: begin
        if (!item.pin_level) begin
          pulse_edge          = 1'b1;
          ref_high_time_next  = t;
          last_level_next     = 1'b0;
          match_count_next    = match_upd;
          prev_high_time_next = t;
          if (match_upd >= sync_count) begin
            longer_is_high_next    = longer_new;
            dec.valid              = 1'b1;
            dec.res.event_kind     = fpsbd_pkg::EV_SYNC;
            dec.res.low_time       = 8'(ref_low_time);
            dec.res.high_time      = 8'(t);
            dec.res.high_longer    = longer_new;
            phase_next             = fpsbd_pkg::PH_BIT_WAIT;
          end else begin
            phase_next = fpsbd_pkg::PH_HUNT_LOW;
          end
        end
      end
      fpsbd_pkg::PH_BIT_WAIT: begin
        if (item.start_sync) begin
          match_count_next = 8'd0;
          phase_next       = fpsbd_pkg::PH_HUNT_LOW;
        end else if (item.pin_level == longer_is_high) begin
          pulse_edge      = 1'b1;
          last_level_next = item.pin_level;
          phase_next      = fpsbd_pkg::PH_BIT_TIME;
        end
      end
      fpsbd_pkg::PH_BIT_TIME: begin
        if (item.start_sync) begin
          match_count_next = 8'd0;
          phase_next       = fpsbd_pkg::PH_HUNT_LOW;
        end else if (item.pin_level != last_level) begin
          pulse_edge          = 1'b1;
          last_level_next     = item.pin_level;
          dec.valid           = 1'b1;
          dec.res.event_kind  = fpsbd_pkg::EV_BIT;
          dec.res.bit_value   = {1'b0, t} > bit_thr;
          phase_next          = fpsbd_pkg::PH_BIT_WAIT;
        end
      end
      default: begin
        if (item.start_sync) begin
          match_count_next = 8'd0;
          phase_next       = fpsbd_pkg::PH_HUNT_LOW;
        end else begin
          phase_next = fpsbd_pkg::PH_IDLE;
        end
      end
    endcase

    tick_count_next = pulse_edge ? '0 : t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= fpsbd_pkg::PH_IDLE;
      tick_count     <= '0;
      match_count    <= '0;
      prev_high_time <= '0;
      ref_low_time   <= '0;
      ref_high_time  <= '0;
      longer_is_high <= 1'b0;
      last_level     <= 1'b0;
    end else if (en) begin
      phase          <= phase_next;
      tick_count     <= tick_count_next;
      match_count    <= match_count_next;
      prev_high_time <= prev_high_time_next;
      ref_low_time   <= ref_low_time_next;
      ref_high_time  <= ref_high_time_next;
      longer_is_high <= longer_is_high_next;
      last_level     <= last_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_count <= fpsbd_pkg::SyncCountReset;
    end else if (cfg_we) begin
      sync_count <= cfg_wdata;
    end
  end

endmodule

@@ rtl/fpsbd_out_reg.sv @@
// result register of the fsk pulse sync and bit decoder
// depends on fpsbd_pkg
module fpsbd_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  fpsbd_pkg::dec_out_t dec,
  output logic                free,
  output logic                m_tvalid,
  input  logic                m_tready,
  output fpsbd_pkg::result_t  res
);

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= dec.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && dec.valid) begin
      res <= dec.res;
    end
  end

endmodule
